FILE: rtl/fcg_pkg.sv
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared types, register codes and constants of the four-corner gradient unit.
// ----------------------------------------------------------------------------
package fcg_pkg;

	localparam int DEF_MAX_DIM  = 4096;
	localparam int COLOR_W      = 24;
	localparam int CHAN_W       = 8;
	localparam int NUM_CHAN     = 3;
	localparam int COORD_W      = 12;
	localparam int DIM_REG_W    = 13;
	localparam int DIM_REG_MAX  = (1 << DIM_REG_W) - 1;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 5;
	localparam int ITEM_IN_W    = 2 * COORD_W;
	localparam int ITEM_OUT_W   = NUM_CHAN * CHAN_W;

	localparam logic [DIM_REG_W-1:0] DEF_IMAGE_DIM = 13'd512;

	typedef enum logic [2:0] {
		REG_TOP_LEFT     = 3'd0,
		REG_TOP_RIGHT    = 3'd1,
		REG_BOTTOM_RIGHT = 3'd2,
		REG_BOTTOM_LEFT  = 3'd3,
		REG_WIDTH        = 3'd4,
		REG_HEIGHT       = 3'd5
	} reg_idx_t;

	// channel 0 is red, 1 green, 2 blue
	function automatic logic [CHAN_W-1:0] color_chan(input logic [COLOR_W-1:0] c,
		input int k);
		logic [CHAN_W-1:0] r;
		case (k)
			0: r = c[23:16];
			1: r = c[15:8];
			default: r = c[7:0];
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/fcg_div.sv
// ----------------------------------------------------------------------------
// fcg_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor; stages hold and collapse bubbles independently.
// ----------------------------------------------------------------------------
module fcg_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 24,
	parameter int Q_W   = fcg_pkg::CHAN_W,
	parameter int LANES = fcg_pkg::NUM_CHAN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [LANES-1:0][NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]                den,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [LANES-1:0][Q_W-1:0]       quot
);
	import fcg_pkg::*;

	logic [Q_W-1:0]                         v_s;
	logic [Q_W-1:0]                         en;
	logic [Q_W-1:0]                         v_in;
	logic [Q_W-1:0][DEN_W-1:0]              den_s;
	logic [Q_W-1:0][LANES-1:0][NUM_W-1:0]   rem_s;
	logic [Q_W-1:0][LANES-1:0][Q_W-1:0]     q_s;
	logic [Q_W-1:0][DEN_W-1:0]              den_in;
	logic [Q_W-1:0][LANES-1:0][NUM_W-1:0]   rem_nxt;
	logic [Q_W-1:0][LANES-1:0][Q_W-1:0]     q_nxt;

	// stall chain, last stage first
	always_comb begin
		en[Q_W-1] = !v_s[Q_W-1] || out_ready;
		for (int j = Q_W - 2; j >= 0; j--) begin
			en[j] = !v_s[j] || en[j+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[Q_W-1];

	always_comb begin
		logic [NUM_W-1:0] rem_i;
		logic [Q_W-1:0]   q_i;
		logic [NUM_W-1:0] trial;
		for (int j = 0; j < Q_W; j++) begin
			v_in[j]   = (j == 0) ? in_valid : v_s[(j == 0) ? 0 : j - 1];
			den_in[j] = (j == 0) ? den : den_s[(j == 0) ? 0 : j - 1];
			for (int l = 0; l < LANES; l++) begin
				rem_i = (j == 0) ? num[l] : rem_s[(j == 0) ? 0 : j - 1][l];
				q_i   = (j == 0) ? '0 : q_s[(j == 0) ? 0 : j - 1][l];
				trial = NUM_W'(den_in[j]) << (Q_W - 1 - j);
				if (rem_i >= trial) begin
					rem_nxt[j][l] = rem_i - trial;
					q_nxt[j][l]   = q_i | (Q_W'(1) << (Q_W - 1 - j));
				end else begin
					rem_nxt[j][l] = rem_i;
					q_nxt[j][l]   = q_i;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int j = 0; j < Q_W; j++) begin
				if (en[j]) begin
					v_s[j] <= v_in[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < Q_W; j++) begin
			if (en[j] && v_in[j]) begin
				den_s[j] <= den_in[j];
				rem_s[j] <= rem_nxt[j];
				q_s[j]   <= q_nxt[j];
			end
		end
	end

	assign quot = q_s[Q_W-1];

endmodule

FILE: rtl/four_corner_gradient_pixel_unit.sv
// ----------------------------------------------------------------------------
// four_corner_gradient_pixel_unit
// Bilinear four-corner gradient: one pixel coordinate in, one RGB item out.
// The unit takes one coordinate item per clock while the output side is not
// stalled and returns its color at the end of the pipeline: one stage clamps the
// coordinate, two multiplier stages form the four corner weights and the
// weighted channel products, one stage sums them, and an eight-stage restoring
// divider yields one quotient bit per stage for all three channels at once.
// Each stage holds its item on its own, so an empty stage keeps taking items
// while a finished result waits at the output. Registers sit on an APB port at
// byte addresses 0x00 (top-left), 0x04 (top-right), 0x08 (bottom-right),
// 0x0c (bottom-left), 0x10 (width) and 0x14 (height); change them only while
// no item is in flight.
// ----------------------------------------------------------------------------
module four_corner_gradient_pixel_unit #(
	parameter int MAX_DIM = fcg_pkg::DEF_MAX_DIM
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fcg_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fcg_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fcg_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fcg_pkg::ITEM_IN_W-1:0]      s_tdata,  // column, row
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fcg_pkg::ITEM_OUT_W-1:0]     m_tdata   // red_out, green_out, blue_out
);
	import fcg_pkg::*;

	localparam int EFF_MAX = (MAX_DIM < DIM_REG_MAX) ? MAX_DIM : DIM_REG_MAX;
	localparam int D_W     = $clog2(EFF_MAX);
	localparam int W_W     = 2 * D_W;
	localparam int NUM_W   = W_W + CHAN_W;

	// configuration registers
	logic [COLOR_W-1:0]   tl_q, tr_q, br_q, bl_q;
	logic [DIM_REG_W-1:0] width_q, height_q;
	reg_idx_t             reg_idx;

	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q     <= '0;
			tr_q     <= '0;
			br_q     <= '0;
			bl_q     <= '0;
			width_q  <= DEF_IMAGE_DIM;
			height_q <= DEF_IMAGE_DIM;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_TOP_LEFT:     tl_q     <= pwdata[COLOR_W-1:0];
				REG_TOP_RIGHT:    tr_q     <= pwdata[COLOR_W-1:0];
				REG_BOTTOM_RIGHT: br_q     <= pwdata[COLOR_W-1:0];
				REG_BOTTOM_LEFT:  bl_q     <= pwdata[COLOR_W-1:0];
				REG_WIDTH:        width_q  <= pwdata[DIM_REG_W-1:0];
				REG_HEIGHT:       height_q <= pwdata[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOP_LEFT:     prdata = APB_DATA_W'(tl_q);
			REG_TOP_RIGHT:    prdata = APB_DATA_W'(tr_q);
			REG_BOTTOM_RIGHT: prdata = APB_DATA_W'(br_q);
			REG_BOTTOM_LEFT:  prdata = APB_DATA_W'(bl_q);
			REG_WIDTH:        prdata = APB_DATA_W'(width_q);
			REG_HEIGHT:       prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// effective last column and row, and divisor terms
	logic [D_W:0]   w_cl, h_cl;
	logic [D_W-1:0] wm1, hm1, dx_c, dy_c;

	always_comb begin
		if (width_q == '0) begin
			w_cl = (D_W+1)'(1);
		end else if (32'(width_q) > 32'(MAX_DIM)) begin
			w_cl = (D_W+1)'(MAX_DIM);
		end else begin
			w_cl = (D_W+1)'(width_q);
		end
		if (height_q == '0) begin
			h_cl = (D_W+1)'(1);
		end else if (32'(height_q) > 32'(MAX_DIM)) begin
			h_cl = (D_W+1)'(MAX_DIM);
		end else begin
			h_cl = (D_W+1)'(height_q);
		end
		wm1  = D_W'(w_cl - (D_W+1)'(1));
		hm1  = D_W'(h_cl - (D_W+1)'(1));
		dx_c = (wm1 == '0) ? D_W'(1) : wm1;
		dy_c = (hm1 == '0) ? D_W'(1) : hm1;
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic d_in_ready;

	assign en4      = !v_s4 || d_in_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: clamp coordinates
	logic [COORD_W-1:0] col_in, row_in;
	logic [D_W-1:0]     x_c, y_c;
	logic [D_W-1:0]     x_s1, y_s1, dxx_s1, dyy_s1, dx_s1, dy_s1;

	assign col_in = s_tdata[COORD_W-1:0];
	assign row_in = s_tdata[2*COORD_W-1:COORD_W];
	assign x_c    = (32'(col_in) > 32'(wm1)) ? wm1 : D_W'(col_in);
	assign y_c    = (32'(row_in) > 32'(hm1)) ? hm1 : D_W'(row_in);

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			x_s1   <= x_c;
			y_s1   <= y_c;
			dxx_s1 <= dx_c - x_c;
			dyy_s1 <= dy_c - y_c;
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
		end
	end

	// stage 2: corner weights and divisor
	logic [W_W-1:0] wtl_s2, wtr_s2, wbr_s2, wbl_s2, den_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			wtl_s2 <= W_W'(dxx_s1) * W_W'(dyy_s1);
			wtr_s2 <= W_W'(x_s1) * W_W'(dyy_s1);
			wbr_s2 <= W_W'(x_s1) * W_W'(y_s1);
			wbl_s2 <= W_W'(dxx_s1) * W_W'(y_s1);
			den_s2 <= W_W'(dx_s1) * W_W'(dy_s1);
		end
	end

	// stage 3: weighted channel products
	logic [NUM_CHAN-1:0][3:0][NUM_W-1:0] prod_s3;
	logic [W_W-1:0]                      den_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			den_s3 <= den_s2;
			for (int k = 0; k < NUM_CHAN; k++) begin
				prod_s3[k][0] <= NUM_W'(wtl_s2) * NUM_W'(color_chan(tl_q, k));
				prod_s3[k][1] <= NUM_W'(wtr_s2) * NUM_W'(color_chan(tr_q, k));
				prod_s3[k][2] <= NUM_W'(wbr_s2) * NUM_W'(color_chan(br_q, k));
				prod_s3[k][3] <= NUM_W'(wbl_s2) * NUM_W'(color_chan(bl_q, k));
			end
		end
	end

	// stage 4: numerator sums
	logic [NUM_CHAN-1:0][NUM_W-1:0] num_s4;
	logic [W_W-1:0]                 den_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			den_s4 <= den_s3;
			for (int k = 0; k < NUM_CHAN; k++) begin
				num_s4[k] <= NUM_W'(prod_s3[k][0] + prod_s3[k][1]
					+ prod_s3[k][2] + prod_s3[k][3]);
			end
		end
	end

	// stages 5 to 12: divide, the result never exceeds one channel's range
	logic [NUM_CHAN-1:0][CHAN_W-1:0] quot;

	fcg_div #(
		.NUM_W (NUM_W),
		.DEN_W (W_W),
		.Q_W   (CHAN_W),
		.LANES (NUM_CHAN)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (d_in_ready),
		.num       (num_s4),
		.den       (den_s4),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.quot      (quot)
	);

	assign m_tdata = {quot[2], quot[1], quot[0]};

`ifndef SYNTHESIS
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("first stage empty but input not ready");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en2) |=> (v_s1 && $stable(x_s1) && $stable(y_s1)))
		else $error("stalled item in first stage lost or changed");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (den_s2 != '0))
		else $error("zero divisor reached the pipeline");
`endif

endmodule
